// ===== rtl/ttcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared types and codes of the text terminal character writer.
// ----------------------------------------------------------------------------
package ttcw_pkg;

   localparam logic       CMD_PUT      = 1'b0;
   localparam logic       CMD_READ     = 1'b1;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] BLANK_CODE   = 8'd0;

   typedef struct packed {
      logic        command;
      logic [7:0]  char_code;
      logic [12:0] read_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [5:0] cursor_row;
      logic [6:0] cursor_col;
      logic       scrolled;
      logic       echo_valid;
      logic [7:0] terminal_byte;
   } rsp_type;

endpackage

// ===== rtl/ttcw_cell_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcw_cell_ram
// Character store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ttcw_cell_ram #(
   parameter int DEPTH = 4800,
   parameter int AW    = 13
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/text_terminal_char_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_char_writer
// A put that does not scroll registers its result in the cycle after the
//   transfer; a read first waits in S_RDWAIT for the registered store read port.
// A scroll copies the rows up through the store's write and read ports, then
//   blanks the bottom row; intake is stalled meanwhile.
// Throughput: one put per cycle unless a scroll or a held result stalls intake; a read blocks intake while it waits.
// Reset: a clearing pass writes zero to all NUM_ROWS*NUM_COLS cells, one per
//   cycle, and a flush state follows before the first transfer is taken.
// ----------------------------------------------------------------------------
module text_terminal_char_writer
   import ttcw_pkg::*;
#(
   parameter int NUM_ROWS = 60,
   parameter int NUM_COLS = 80
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Store geometry, all derived from the screen size.
   localparam int CELLS = NUM_ROWS * NUM_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(NUM_ROWS);
   localparam int CW    = $clog2(NUM_COLS);

   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_COPY = AW'((NUM_ROWS - 1) * NUM_COLS - 1);
   localparam logic [RW-1:0] LAST_ROW  = RW'(NUM_ROWS - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(NUM_COLS - 1);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_FLUSH  = 3'd1;
   localparam logic [2:0] S_IDLE   = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_COPY   = 3'd4;
   localparam logic [2:0] S_BLANK  = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;        // sweep pointer for clear and scroll
   logic [AW-1:0] wptr_ff, wptr_in;      // delayed write address of the sweep
   logic          wvalid_ff, wvalid_in;  // a sweep write is pending
   logic          wzero_ff, wzero_in;    // that write blanks the cell
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] base_ff, base_in;      // cell index of column 0 of the row
   logic [AW-1:0] cur_ff, cur_in;        // cell index of the cursor
   logic [7:0]    ch_ff, ch_in;
   logic          oob_ff, oob_in;
   rsp_type       out_ff;
   logic          out_valid_ff;

   logic          accept;
   logic          take_out;
   logic          load;
   logic          scroll_flag;
   logic          echo_flag;
   logic [7:0]    rdata_sel;
   logic [7:0]    echo_byte;
   rsp_type       ld;
   logic [31:0]   row_w;
   logic [31:0]   col_w;
   logic [31:0]   rd_ext;

   // Shared address adder: one row ahead, either of the sweep pointer
   // (scroll source) or of the current row base (line feed).
   logic [AW-1:0] add_a;
   logic [AW:0]   add_sum;

   // Store port signals.
   logic          direct_we;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   assign add_a   = (state_ff == S_COPY) ? ptr_ff : base_ff;
   assign add_sum = {1'b0, add_a} + (AW + 1)'(NUM_COLS);

   // Stall while sequencing, or while the result slot is full and held.
   assign take_out  = out_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || (out_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign rd_ext = 32'(req_data.read_address);

   // Sweep writes win the port; a put writes directly only from idle,
   // when no sweep write can be pending.
   assign ram_we    = wvalid_ff || direct_we;
   assign ram_waddr = wvalid_ff ? wptr_ff : cur_ff;
   assign ram_wdata = wvalid_ff ? (wzero_ff ? BLANK_CODE : ram_rdata)
                                : req_data.char_code;
   assign ram_raddr = (state_ff == S_COPY) ? add_sum[AW-1:0] : rd_ext[AW-1:0];

   ttcw_cell_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      wptr_in     = wptr_ff;
      wvalid_in   = 1'b0;
      wzero_in    = 1'b0;
      row_in      = row_ff;
      col_in      = col_ff;
      base_in     = base_ff;
      cur_in      = cur_ff;
      ch_in       = ch_ff;
      oob_in      = oob_ff;
      direct_we   = 1'b0;
      load        = 1'b0;
      scroll_flag = 1'b0;
      echo_flag   = 1'b0;
      echo_byte   = 8'd0;
      rdata_sel   = 8'd0;

      case (state_ff)
         S_CLEAR: begin
            // Blank one cell per cycle after reset.
            wvalid_in = 1'b1;
            wzero_in  = 1'b1;
            wptr_in   = ptr_ff;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == LAST_CELL) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            // Let the last clearing write land.
            ptr_in   = '0;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               ch_in = req_data.char_code;
               if (req_data.command == CMD_READ) begin
                  oob_in   = (rd_ext >= 32'(CELLS));
                  state_in = S_RDWAIT;
               end else begin
                  direct_we = (req_data.char_code != NEWLINE_CODE);
                  if (req_data.char_code == NEWLINE_CODE || col_ff == LAST_COL) begin
                     col_in = '0;
                     if (row_ff != LAST_ROW) begin
                        row_in  = row_ff + 1'b1;
                        base_in = add_sum[AW-1:0];
                        cur_in  = add_sum[AW-1:0];
                        load    = 1'b1;
                     end else begin
                        // Bottom row passed: scroll; base stays on the last row.
                        cur_in   = base_ff;
                        ptr_in   = '0;
                        state_in = S_COPY;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                     cur_in = cur_ff + 1'b1;
                     load   = 1'b1;
                  end
                  echo_flag = 1'b1;
                  echo_byte = req_data.char_code;
               end
            end
         end
         S_RDWAIT: begin
            load      = 1'b1;
            rdata_sel = oob_ff ? BLANK_CODE : ram_rdata;
            state_in  = S_IDLE;
         end
         S_COPY: begin
            // Read one row ahead; the data is written in the next cycle to the registered sweep address.
            wvalid_in = 1'b1;
            wptr_in   = ptr_ff;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == LAST_COPY) begin
               state_in = S_BLANK;
            end
         end
         S_BLANK: begin
            wvalid_in = 1'b1;
            wzero_in  = 1'b1;
            wptr_in   = ptr_ff;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == LAST_CELL) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            load        = 1'b1;
            scroll_flag = 1'b1;
            echo_flag   = 1'b1;
            echo_byte   = ch_ff;
            ptr_in      = '0;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Cursor outputs keep the low bits of the counters.
   assign row_w = 32'(row_in);
   assign col_w = 32'(col_in);

   always_comb begin
      ld.read_data     = rdata_sel;
      ld.cursor_row    = row_w[5:0];
      ld.cursor_col    = col_w[6:0];
      ld.scrolled      = scroll_flag;
      ld.echo_valid    = echo_flag;
      ld.terminal_byte = echo_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         wvalid_ff    <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         cur_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         wvalid_ff <= wvalid_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         base_ff   <= base_in;
         cur_ff    <= cur_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (take_out) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      wptr_ff  <= wptr_in;
      wzero_ff <= wzero_in;
      ch_ff    <= ch_in;
      oob_ff   <= oob_in;
      if (load) begin
         out_ff <= ld;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
